/* rtl/reaction_diffusion_rhs_stencil_unit_assert.svh */
// assertion macros for the reaction-diffusion stencil unit and its checker
// no dependencies; the including scope provides clk_i and rst_ni
`ifndef REACTION_DIFFUSION_RHS_STENCIL_UNIT_ASSERT_SVH
`define REACTION_DIFFUSION_RHS_STENCIL_UNIT_ASSERT_SVH

// clocked property, off while reset is asserted
`define RDS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked property that also holds during reset
`define RDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/rds_pkg.sv */
// shared types and constants of the reaction-diffusion stencil unit
// no dependencies
package rds_pkg;

  localparam int unsigned GRID_ROWS_DEF = 64;
  localparam int unsigned GRID_COLS_DEF = 64;
  localparam int unsigned PADDR_W       = 4;

  // register reset values (Q16.16)
  localparam logic [31:0] COEF_A_RST  = 32'd65536;
  localparam logic [31:0] COEF_B_RST  = 32'd222822;
  localparam logic [31:0] DIFF_RST    = 32'd0;
  localparam logic [16:0] SPACING_RST = 17'd1008;

  // forcing disc and switch-on constants
  localparam int CX_Q    = 19661;
  localparam int CY_Q    = 32768;
  localparam int R2_Q32  = 42949673;
  localparam int T_ON_Q  = 72090;
  localparam int FORCE_Q = 327680;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic [1:0] {
    REG_COEF_A,
    REG_COEF_B,
    REG_DIFF,
    REG_SPACING
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_CALC,
    ST_DONE
  } state_e;

  // order in which the five stencil taps are read
  typedef enum logic [2:0] {
    TAP_CTR,
    TAP_UP,
    TAP_DN,
    TAP_LF,
    TAP_RT
  } tap_e;

  // steps of the shared multiplier
  typedef enum logic [2:0] {
    CS_BU,
    CS_UU,
    CS_UUV,
    CS_DLU,
    CS_DLV,
    CS_DX2,
    CS_DY2,
    CS_DIST
  } calc_step_e;

  typedef struct packed {
    logic               operation;
    logic [5:0]         cell_row;
    logic [5:0]         cell_col;
    logic signed [31:0] load_u;
    logic signed [31:0] load_v;
    logic [30:0]        time_now;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         out_row;
    logic [5:0]         out_col;
    logic signed [31:0] du;
    logic signed [31:0] dv;
  } out_item_t;

endpackage

/* rtl/rds_ram.sv */
// generic single-port ram with registered read
// no dependencies
module rds_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* rtl/reaction_diffusion_rhs_stencil_unit.sv */
// brusselator right-hand side on a periodic grid, five-point stencil
// depends on rds_pkg and rds_ram
//
//  channel   direction  handshake                   payload
//  in        input      in_valid_i / in_ready_o     rds_pkg::in_item_t
//  out       output     out_valid_o / out_ready_i   rds_pkg::out_item_t
//  apb       input      psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// a load transaction: capture, then one ram write
// an evaluate transaction: capture, five reads of the single
//   ram port, eight steps of the one shared 32x32 multiplier, result hand-off
// the result waits in the output register; the next item is taken meanwhile
// reset clears control and config registers; the cell ram holds garbage until loaded
module reaction_diffusion_rhs_stencil_unit #(
  parameter int unsigned GRID_ROWS = rds_pkg::GRID_ROWS_DEF,
  parameter int unsigned GRID_COLS = rds_pkg::GRID_COLS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rds_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rds_pkg::out_item_t           out_item_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rds_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import rds_pkg::*;

  localparam int unsigned CELLS   = GRID_ROWS * GRID_COLS;
  localparam int unsigned AW      = $clog2(CELLS);
  localparam int unsigned RW      = $clog2(GRID_ROWS);
  localparam int unsigned CW      = $clog2(GRID_COLS);
  localparam int unsigned PXW     = RW + 18;
  localparam int unsigned PYW     = CW + 18;
  // reciprocals for the 6-bit coordinate reduction
  localparam int unsigned RECIP_R = 4096 / GRID_ROWS;
  localparam int unsigned RECIP_C = 4096 / GRID_COLS;

  // ---------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // q16.16 product back to 32 bits: floor by 2^16, then saturate
  function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
    return sat32(p >>> 16);
  endfunction

  // coordinate modulo grid size, reciprocal estimate plus one correction
  function automatic logic [17:0] reduce(input logic [5:0] x, input logic [17:0] recip,
                                         input logic [17:0] n);
    logic [17:0] q;
    logic [17:0] rem;
    q   = (18'(x) * recip) >> 12;
    rem = 18'(x) - 18'(q * n);
    if (rem >= n) begin
      rem = rem - n;
    end
    return rem;
  endfunction

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic signed [31:0] coef_a_q, coef_b_q, diff_q;
  logic [16:0]        spacing_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q  <= COEF_A_RST;
      coef_b_q  <= COEF_B_RST;
      diff_q    <= DIFF_RST;
      spacing_q <= SPACING_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COEF_A:  coef_a_q  <= pwdata;
        REG_COEF_B:  coef_b_q  <= pwdata;
        REG_DIFF:    diff_q    <= pwdata;
        REG_SPACING: spacing_q <= pwdata[16:0];
        default:     coef_a_q  <= coef_a_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_COEF_A:  prdata = coef_a_q;
      REG_COEF_B:  prdata = coef_b_q;
      REG_DIFF:    prdata = diff_q;
      REG_SPACING: prdata = {15'd0, spacing_q};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------
  state_e     state_q, state_d;
  tap_e       tap_q;
  calc_step_e step_q;
  logic       out_valid_q;
  logic       in_acc;
  logic       out_load;
  logic       ram_we;
  logic [AW-1:0] ram_addr;
  logic [63:0]   ram_rdata;

  // captured item
  logic          op_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [30:0]   time_q;
  logic [63:0]   wdata_q;
  logic [RW-1:0] row_red;
  logic [CW-1:0] col_red;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign row_red    = RW'(reduce(in_item_i.cell_row, 18'(RECIP_R), 18'(GRID_ROWS)));
  assign col_red    = CW'(reduce(in_item_i.cell_col, 18'(RECIP_C), 18'(GRID_COLS)));

  // stencil tap coordinates with periodic wrap
  logic [RW-1:0] tap_row;
  logic [CW-1:0] tap_col;
  logic [RW-1:0] row_up, row_dn;
  logic [CW-1:0] col_lf, col_rt;

  assign row_up = (row_q == '0) ? RW'(GRID_ROWS - 1) : row_q - RW'(1);
  assign row_dn = (row_q == RW'(GRID_ROWS - 1)) ? '0 : row_q + RW'(1);
  assign col_lf = (col_q == '0) ? CW'(GRID_COLS - 1) : col_q - CW'(1);
  assign col_rt = (col_q == CW'(GRID_COLS - 1)) ? '0 : col_q + CW'(1);

  always_comb begin
    tap_row = row_q;
    tap_col = col_q;
    case (tap_q)
      TAP_UP:  tap_row = row_up;
      TAP_DN:  tap_row = row_dn;
      TAP_LF:  tap_col = col_lf;
      TAP_RT:  tap_col = col_rt;
      default: tap_row = row_q;
    endcase
  end

  // in the write cycle tap_q rests at the centre, so both use the same address
  assign ram_addr = AW'(AW'(tap_row) * AW'(GRID_ROWS == 0 ? 0 : GRID_COLS)) + AW'(tap_col);

  always_comb begin
    state_d  = state_q;
    ram_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_item_i.operation == OP_EVAL) ? ST_READ : ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_READ: begin
        if (tap_q == TAP_RT) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (step_q == CS_DIST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // tap and step counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q  <= TAP_CTR;
      step_q <= CS_BU;
    end else begin
      if (state_q == ST_READ && tap_q != TAP_RT) begin
        tap_q <= tap_e'(tap_q + 3'd1);
      end else begin
        tap_q <= TAP_CTR;
      end
      if (state_q == ST_CALC && step_q != CS_DIST) begin
        step_q <= calc_step_e'(step_q + 3'd1);
      end else begin
        step_q <= CS_BU;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= in_item_i.operation;
      row_q   <= row_red;
      col_q   <= col_red;
      time_q  <= in_item_i.time_now;
      wdata_q <= {in_item_i.load_u, in_item_i.load_v};
    end
  end

  rds_ram #(
    .WIDTH (64),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wdata_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // read capture: centre first, then neighbour sums
  // ---------------------------------------------------------------------
  logic               rd_vld_q;
  tap_e               rd_tap_q;
  logic signed [31:0] u_q, v_q;
  logic signed [34:0] sum_u_q, sum_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == ST_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tap_q <= tap_q;
    if (rd_vld_q) begin
      if (rd_tap_q == TAP_CTR) begin
        u_q     <= ram_rdata[63:32];
        v_q     <= ram_rdata[31:0];
        sum_u_q <= '0;
        sum_v_q <= '0;
      end else begin
        sum_u_q <= sum_u_q + 35'($signed(ram_rdata[63:32]));
        sum_v_q <= sum_v_q + 35'($signed(ram_rdata[31:0]));
      end
    end
  end

  // ---------------------------------------------------------------------
  // shared multiplier and its step datapath
  // ---------------------------------------------------------------------
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_q;
  logic signed [31:0] prod_qs;
  logic [PXW-1:0]     px_q;
  logic [PYW-1:0]     py_q;
  logic signed [31:0] dx, dy;
  logic signed [31:0] lapu_q, lapv_q, bu_q, uuv_q, dlu_q, dlv_q, term_q;
  logic signed [63:0] sqx_q;
  logic               hit_q;

  assign prod_qs = qscale(prod_q);
  assign dx      = $signed(32'(px_q)) - 32'(CX_Q);
  assign dy      = $signed(32'(py_q)) - 32'(CY_Q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      CS_BU:   begin mul_a = coef_b_q; mul_b = u_q;    end
      CS_UU:   begin mul_a = u_q;      mul_b = u_q;    end
      CS_UUV:  begin mul_a = prod_qs;  mul_b = v_q;    end
      CS_DLU:  begin mul_a = diff_q;   mul_b = lapu_q; end
      CS_DLV:  begin mul_a = diff_q;   mul_b = lapv_q; end
      CS_DX2:  begin mul_a = dx;       mul_b = dx;     end
      CS_DY2:  begin mul_a = dy;       mul_b = dy;     end
      default: begin mul_a = '0;       mul_b = '0;     end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    // disc position of the cell, (index + 1) * spacing
    px_q   <= PXW'((RW + 1)'(row_q) + (RW + 1)'(1)) * PXW'(spacing_q);
    py_q   <= PYW'((CW + 1)'(col_q) + (CW + 1)'(1)) * PYW'(spacing_q);
    if (state_q == ST_CALC) begin
      case (step_q)
        CS_UU: begin
          bu_q   <= prod_qs;
          lapu_q <= sat32(64'(sum_u_q) - (64'(u_q) <<< 2));
          lapv_q <= sat32(64'(sum_v_q) - (64'(v_q) <<< 2));
        end
        CS_DLU: uuv_q <= prod_qs;
        CS_DLV: begin
          dlu_q  <= prod_qs;
          term_q <= sat32(64'(bu_q) - 64'(uuv_q));
        end
        CS_DX2:  dlv_q <= prod_qs;
        CS_DY2:  sqx_q <= prod_q;
        CS_DIST: hit_q <= (sqx_q + prod_q) <= 64'(R2_Q32);
        default: sqx_q <= sqx_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // final sums and output register
  // ---------------------------------------------------------------------
  logic signed [63:0] force_q16;
  out_item_t          out_item_q;

  assign force_q16 = (hit_q && time_q >= 31'(T_ON_Q)) ? 64'(FORCE_Q) : 64'sd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && op_q == OP_EVAL) begin
      out_item_q.out_row <= 6'(row_q);
      out_item_q.out_col <= 6'(col_q);
      out_item_q.du      <= sat32(64'(dlu_q) + 64'(coef_a_q) - 64'(term_q)
                                  - 64'(u_q) + force_q16);
      out_item_q.dv      <= sat32(64'(dlv_q) + 64'(term_q));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* rtl/rds_checker.sv */
// port-level checks for the reaction-diffusion stencil unit, bound to the top level
// depends on rds_pkg and reaction_diffusion_rhs_stencil_unit_assert.svh
`include "reaction_diffusion_rhs_stencil_unit_assert.svh"

module rds_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input rds_pkg::in_item_t            in_item_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input rds_pkg::out_item_t           out_item_o,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [rds_pkg::PADDR_W-1:0]  paddr,
  input logic [31:0]                  pwdata,
  input logic [31:0]                  prdata,
  input logic                         pready
);
  import rds_pkg::*;

  // output transaction held until taken
  `RDS_ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "out valid dropped")
  `RDS_ASSERT_CLK(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_item_o), "out payload moved")
  // one item in flight: ready drops right after an accept
  `RDS_ASSERT_CLK(a_one_item, in_valid_i && in_ready_o |=> !in_ready_o, "second item taken while busy")
  // a load never creates a result
  `RDS_ASSERT_CLK(a_load_silent, in_valid_i && in_ready_o && in_item_i.operation == OP_LOAD && !out_valid_o |=> !out_valid_o, "result after load")
  `RDS_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind reaction_diffusion_rhs_stencil_unit rds_checker u_rds_checker (.*);
